/* rtl/core/modbus_rtu_read_frame_engine_top_defines.svh */
// Assertion macros shared by the Modbus RTU read frame engine RTL.
// Every macro expects aclk and aresetn in scope where it is used.
`ifndef MODBUS_RTU_READ_FRAME_ENGINE_TOP_DEFINES_SVH
`define MODBUS_RTU_READ_FRAME_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mbrf assertion failed");

// Next-cycle implication, checked outside reset.
`define MBRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mbrf assertion failed");

`endif

/* rtl/core/mbrf_pkg.sv */
// Types, constants and the CRC-16/MODBUS byte step for the read frame engine.
// No dependencies; every RTL module file imports this package.
`timescale 1ns / 1ps

package mbrf_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] QTY_HIGH = 8'h00;
    localparam logic [7:0] QTY_LOW  = 8'h02;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] FUNCTION_CODE_RESET = 8'h04;

    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_FUNCTION_CODE = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RX_BYTE = 1'b1;

    localparam logic RESULT_TX   = 1'b0;
    localparam logic RESULT_RESP = 1'b1;

    localparam logic [3:0] RX_VALUE_FIRST = 4'd3;
    localparam logic [3:0] RX_CRC_LOW     = 4'd7;

    typedef enum logic {
        ENTRY_REQUEST  = 1'b0,
        ENTRY_RESPONSE = 1'b1
    } entry_kind_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] reg_address;
        logic [7:0]  rx_byte;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  tx_byte;
        logic        last_byte;
        logic [31:0] value_bits;
        logic        crc_ok;
    } out_t;

    typedef struct packed {
        entry_kind_t entry_kind;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] reg_address;
        logic [31:0] value_bits;
        logic        crc_ok;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/core/mbrf_fifo.sv */
// Show-ahead register queue between the front and back of the frame engine.
// Depends on mbrf_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "modbus_rtu_read_frame_engine_top_defines.svh"

module mbrf_fifo #(
    parameter int DEPTH = mbrf_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  mbrf_pkg::entry_t       push_data,
    input  logic                   pop,
    output mbrf_pkg::entry_t       head_data,
    output mbrf_pkg::queue_status_t status
);
    import mbrf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign head_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `MBRF_ASSERT_SAME(a_no_overflow, push && !pop, !status.full)
    `MBRF_ASSERT_SAME(a_no_underflow, pop, !status.empty)

endmodule

/* rtl/core/mbrf_front.sv */
// Front of the frame engine: configuration registers, input acceptance,
// receive CRC/value tracking and queue entry generation. Depends on mbrf_pkg.
`timescale 1ns / 1ps

module mbrf_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_addr,
    input  logic [7:0]              cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  mbrf_pkg::in_t           s_data,
    input  mbrf_pkg::queue_status_t q_status,
    output logic                    q_push,
    output mbrf_pkg::entry_t        q_data
);
    import mbrf_pkg::*;

    logic [7:0]  slave_address_reg;
    logic [7:0]  function_code_reg;
    logic [3:0]  rx_count_reg, rx_count_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [31:0] value_shift_reg, value_shift_next;
    logic        crc_low_match_reg, crc_low_match_next;
    logic        accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= SLAVE_ADDRESS_RESET;
            function_code_reg <= FUNCTION_CODE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_wdata;
                CFG_FUNCTION_CODE: function_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        rx_count_next      = rx_count_reg;
        rx_crc_next        = rx_crc_reg;
        value_shift_next   = value_shift_reg;
        crc_low_match_next = crc_low_match_reg;
        q_push             = 1'b0;
        q_data.entry_kind    = ENTRY_REQUEST;
        q_data.slave_address = slave_address_reg;
        q_data.function_code = function_code_reg;
        q_data.reg_address   = s_data.reg_address;
        q_data.value_bits    = value_shift_reg;
        q_data.crc_ok        = crc_low_match_reg && (s_data.rx_byte == rx_crc_reg[15:8]);
        if (accept) begin
            if (s_data.kind == KIND_REQUEST) begin
                q_push             = 1'b1;
                rx_count_next      = '0;
                rx_crc_next        = CRC_INIT;
                value_shift_next   = '0;
                crc_low_match_next = 1'b0;
            end else if (rx_count_reg < RX_CRC_LOW) begin
                rx_crc_next   = crc_byte(rx_crc_reg, s_data.rx_byte);
                rx_count_next = rx_count_reg + 1'b1;
                if (rx_count_reg >= RX_VALUE_FIRST) begin
                    value_shift_next = {value_shift_reg[23:0], s_data.rx_byte};
                end
            end else if (rx_count_reg == RX_CRC_LOW) begin
                crc_low_match_next = (s_data.rx_byte == rx_crc_reg[7:0]);
                rx_count_next      = rx_count_reg + 1'b1;
            end else begin
                q_push             = 1'b1;
                q_data.entry_kind  = ENTRY_RESPONSE;
                rx_count_next      = '0;
                rx_crc_next        = CRC_INIT;
                value_shift_next   = '0;
                crc_low_match_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_count_reg      <= '0;
            rx_crc_reg        <= CRC_INIT;
            value_shift_reg   <= '0;
            crc_low_match_reg <= 1'b0;
        end else begin
            rx_count_reg      <= rx_count_next;
            rx_crc_reg        <= rx_crc_next;
            value_shift_reg   <= value_shift_next;
            crc_low_match_reg <= crc_low_match_next;
        end
    end

endmodule

/* rtl/core/mbrf_back.sv */
// Back of the frame engine: expands queued requests into eight framed bytes
// with a running CRC, passes responses through, owns the output register.
// Depends on mbrf_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "modbus_rtu_read_frame_engine_top_defines.svh"

module mbrf_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mbrf_pkg::entry_t        q_head,
    input  mbrf_pkg::queue_status_t q_status,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output mbrf_pkg::out_t          m_data
);
    import mbrf_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;
    logic        load;
    logic [7:0]  tx_sel;
    logic        head_is_req;
    logic        tx_last_out;
    logic        last_load;

    assign load = (!m_valid_reg || m_ready) && !q_status.empty;

    always_comb begin
        case (idx_reg)
            3'd0:    tx_sel = q_head.slave_address;
            3'd1:    tx_sel = q_head.function_code;
            3'd2:    tx_sel = q_head.reg_address[15:8];
            3'd3:    tx_sel = q_head.reg_address[7:0];
            3'd4:    tx_sel = QTY_HIGH;
            3'd5:    tx_sel = QTY_LOW;
            3'd6:    tx_sel = crc_reg[7:0];
            default: tx_sel = crc_reg[15:8];
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        q_pop        = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            if (q_head.entry_kind == ENTRY_RESPONSE) begin
                q_pop                  = 1'b1;
                m_data_next.result_kind = RESULT_RESP;
                m_data_next.tx_byte     = '0;
                m_data_next.last_byte   = 1'b0;
                m_data_next.value_bits  = q_head.value_bits;
                m_data_next.crc_ok      = q_head.crc_ok;
            end else begin
                m_data_next.result_kind = RESULT_TX;
                m_data_next.tx_byte     = tx_sel;
                m_data_next.last_byte   = (idx_reg == 3'd7);
                m_data_next.value_bits  = '0;
                m_data_next.crc_ok      = 1'b0;
                idx_next                = idx_reg + 1'b1;
                if (idx_reg < 3'd6) begin
                    crc_next = crc_byte(crc_reg, tx_sel);
                end
                if (idx_reg == 3'd7) begin
                    q_pop    = 1'b1;
                    crc_next = CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign head_is_req = !q_status.empty && q_head.entry_kind == ENTRY_REQUEST;
    assign tx_last_out = m_valid_reg && m_data_reg.last_byte;
    assign last_load   = load && q_head.entry_kind == ENTRY_REQUEST && idx_reg == 3'd7;

    `MBRF_ASSERT_SAME(a_mid_request_head, idx_reg != 3'd0, head_is_req)
    `MBRF_ASSERT_SAME(a_last_is_tx, tx_last_out, m_data_reg.result_kind == RESULT_TX)
    `MBRF_ASSERT_NEXT(a_last_wraps, last_load, idx_reg == 3'd0 && crc_reg == CRC_INIT)

endmodule

/* rtl/core/modbus_rtu_read_frame_engine_top.sv */
// Modbus RTU read frame engine: a request transaction (kind 0) yields eight result
// transactions, the framed read request with CRC-16/MODBUS, low CRC byte first, and
// restarts the receiver; the ninth received-byte transaction (kind 1) of a response
// yields one result with the big-endian value of bytes 3..6 and the CRC match flag.
// Input transactions are taken one per cycle while the QUEUE_DEPTH-entry queue has
// room; the output side delivers one result per cycle while m_ready is high and
// the queue is not empty. Registers slave_address (index 0) and function_code
// (index 1) are written through cfg_we/cfg_addr/cfg_wdata. Depends on mbrf_pkg and
// submodules.
`timescale 1ns / 1ps

module modbus_rtu_read_frame_engine_top #(
    parameter int QUEUE_DEPTH = mbrf_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_addr,
    input  logic [7:0]     cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  mbrf_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mbrf_pkg::out_t m_data
);
    import mbrf_pkg::*;

    entry_t        push_data;
    entry_t        head_data;
    queue_status_t q_status;
    logic          q_push;
    logic          q_pop;

    mbrf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    mbrf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head_data (head_data),
        .status    (q_status)
    );

    mbrf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (head_data),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
